### rtl/byte_frame_aggregator_idle_flush_core_defines.svh
// Assertion macros used by the checker file of the frame aggregator.
`ifndef BYTE_FRAME_AGGREGATOR_IDLE_FLUSH_CORE_DEFINES_SVH
`define BYTE_FRAME_AGGREGATOR_IDLE_FLUSH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfa check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfa check failed");

`endif

### rtl/bfa_pkg.sv
// Shared constants and codes of the byte frame aggregator.
`default_nettype none

package bfa_pkg;

    localparam int STORE_DEPTH_DEF = 64;

    localparam int THR_W  = 7;
    localparam int TMO_W  = 16;
    localparam int BYTE_W = 8;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [THR_W-1:0] THR_RESET = 7'd64;
    localparam logic [TMO_W-1:0] TMO_RESET = 16'd6;

    // register index, selected by paddr[2]
    localparam logic REG_FLUSH_THRESHOLD = 1'b0;
    localparam logic REG_IDLE_TIMEOUT    = 1'b1;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic CAUSE_THRESHOLD = 1'b0;
    localparam logic CAUSE_IDLE      = 1'b1;

endpackage

`default_nettype wire

### rtl/bfa_if.sv
// Valid/ready channel interfaces for request and frame beats.
`default_nettype none

interface bfa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [bfa_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface bfa_frame_if;
    logic                          valid;
    logic                          ready;
    logic [bfa_pkg::BYTE_W-1:0]    frame_byte;
    logic                          frame_last;
    logic                          flush_cause;

    modport source (output valid, output frame_byte, output frame_last,
                    output flush_cause, input ready);
    modport sink   (input valid, input frame_byte, input frame_last,
                    input flush_cause, output ready);
endinterface

`default_nettype wire

### rtl/byte_frame_aggregator_idle_flush_core.sv
// Byte frame aggregator: collects bytes in a frame memory, flushes on fill or idle.
//
// Channels: item (sink) carries request beats, req_type 0 = received byte,
// 1 = time tick. frame (source) carries flushed bytes oldest first, with
// frame_last on the final beat and flush_cause (0 threshold, 1 idle timeout).
// APB port: register 0 flush_threshold at 0x0, register 1 idle_timeout at 0x4.
// Flow: a byte or tick that flushes nothing is taken without dropping item.ready.
// A beat that flushes a frame holds item.ready low while the frame memory is
// walked: for each byte a read state (ST_READ) and then a load state (ST_LOAD),
// and the walk waits longer while frame stalls. From the accepting beat the walk
// goes to ST_READ, then ST_LOAD, which loads the first frame beat into the output
// register. The memory read port sets the per-byte pace.
// The output register holds the last beat while the next item is accepted.
// When frame.ready is low the current beat holds and the walk waits for it.
// Reset: fill and idle counts cleared, registers to 64 and 6, no beat pending.
// The memory contents are not cleared; only entries written since the last
// flush are read.
`default_nettype none

module byte_frame_aggregator_idle_flush_core #(
    parameter int STORE_DEPTH = bfa_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    bfa_req_if.sink                            item,
    bfa_frame_if.source                        frame,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bfa_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [bfa_pkg::DATA_W-1:0]    pwdata,
    output logic      [bfa_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

    // configuration
    logic [bfa_pkg::THR_W-1:0] thr_reg;
    logic [bfa_pkg::TMO_W-1:0] tmo_reg;
    logic                      cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= bfa_pkg::THR_RESET;
            tmo_reg <= bfa_pkg::TMO_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == bfa_pkg::REG_FLUSH_THRESHOLD)
                thr_reg <= pwdata[bfa_pkg::THR_W-1:0];
            else
                tmo_reg <= pwdata[bfa_pkg::TMO_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == bfa_pkg::REG_IDLE_TIMEOUT)
            prdata = {{(bfa_pkg::DATA_W-bfa_pkg::TMO_W){1'b0}}, tmo_reg};
        else
            prdata = {{(bfa_pkg::DATA_W-bfa_pkg::THR_W){1'b0}}, thr_reg};
    end

    // effective limits
    logic [CNT_W-1:0]          thr_eff;
    logic [bfa_pkg::TMO_W-1:0] tmo_eff;

    always_comb
    begin
        if (thr_reg == '0)
            thr_eff = CNT_W'(1);
        else if (thr_reg > bfa_pkg::THR_W'(STORE_DEPTH))
            thr_eff = CNT_W'(STORE_DEPTH);
        else
            thr_eff = thr_reg[CNT_W-1:0];
        tmo_eff = (tmo_reg == '0) ? bfa_pkg::TMO_W'(1) : tmo_reg;
    end

    // control state
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [bfa_pkg::TMO_W-1:0] idle_reg, idle_next;
    logic [CNT_W-1:0]          len_reg, len_next;
    logic [IDX_W-1:0]          rd_idx_reg, rd_idx_next;
    logic                      cause_reg, cause_next;
    logic                      fvalid_reg, fvalid_next;
    logic [bfa_pkg::BYTE_W-1:0] fbyte_reg, fbyte_next;
    logic                      flast_reg, flast_next;
    logic                      fcause_reg, fcause_next;

    // frame memory
    logic [bfa_pkg::BYTE_W-1:0] frame_mem [STORE_DEPTH];
    logic [bfa_pkg::BYTE_W-1:0] mem_rdata_reg;
    logic                       mem_we;
    logic                       mem_re;

    logic                      in_acc;
    logic                      has_room;
    logic [CNT_W-1:0]          fill_inc;
    logic [bfa_pkg::TMO_W-1:0] idle_inc;
    logic                      rd_last;
    logic                      out_free;

    assign item.ready = (state_reg == ST_IDLE);
    assign in_acc     = item.valid && item.ready;
    assign has_room   = fill_reg < CNT_W'(STORE_DEPTH);
    assign fill_inc   = has_room ? fill_reg + CNT_W'(1) : fill_reg;
    assign idle_inc   = (idle_reg == '1) ? idle_reg : idle_reg + bfa_pkg::TMO_W'(1);
    assign mem_we     = in_acc && (item.req_type == bfa_pkg::REQ_BYTE) && has_room;
    assign mem_re     = (state_reg == ST_READ);
    assign rd_last    = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == len_reg;
    assign out_free   = !fvalid_reg || frame.ready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[fill_reg[IDX_W-1:0]] <= item.rx_byte;
        if (mem_re)
            mem_rdata_reg <= frame_mem[rd_idx_reg];
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idle_next   = idle_reg;
        len_next    = len_reg;
        rd_idx_next = rd_idx_reg;
        cause_next  = cause_reg;
        fvalid_next = fvalid_reg && !frame.ready;
        fbyte_next  = fbyte_reg;
        flast_next  = flast_reg;
        fcause_next = fcause_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (item.req_type == bfa_pkg::REQ_BYTE)
                    begin
                        idle_next = '0;
                        if (fill_inc >= thr_eff)
                        begin
                            len_next    = fill_inc;
                            cause_next  = bfa_pkg::CAUSE_THRESHOLD;
                            rd_idx_next = '0;
                            fill_next   = '0;
                            state_next  = ST_READ;
                        end
                        else
                            fill_next = fill_inc;
                    end
                    else if (fill_reg == '0)
                        idle_next = '0;
                    else if (idle_inc >= tmo_eff)
                    begin
                        len_next    = fill_reg;
                        cause_next  = bfa_pkg::CAUSE_IDLE;
                        rd_idx_next = '0;
                        fill_next   = '0;
                        idle_next   = '0;
                        state_next  = ST_READ;
                    end
                    else
                        idle_next = idle_inc;
                end
            end
            ST_READ:
                state_next = ST_LOAD;
            ST_LOAD:
            begin
                // read data holds until the output register frees up
                if (out_free)
                begin
                    fvalid_next = 1'b1;
                    fbyte_next  = mem_rdata_reg;
                    flast_next  = rd_last;
                    fcause_next = cause_reg;
                    if (rd_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            idle_reg   <= '0;
            len_reg    <= '0;
            rd_idx_reg <= '0;
            cause_reg  <= bfa_pkg::CAUSE_THRESHOLD;
            fvalid_reg <= 1'b0;
            fbyte_reg  <= '0;
            flast_reg  <= 1'b0;
            fcause_reg <= bfa_pkg::CAUSE_THRESHOLD;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            idle_reg   <= idle_next;
            len_reg    <= len_next;
            rd_idx_reg <= rd_idx_next;
            cause_reg  <= cause_next;
            fvalid_reg <= fvalid_next;
            fbyte_reg  <= fbyte_next;
            flast_reg  <= flast_next;
            fcause_reg <= fcause_next;
        end
    end

    assign frame.valid       = fvalid_reg;
    assign frame.frame_byte  = fbyte_reg;
    assign frame.frame_last  = flast_reg;
    assign frame.flush_cause = fcause_reg;

endmodule

`default_nettype wire

### rtl/bfa_checker.sv
// Port-level checker for the frame aggregator, bound to the core module.
`default_nettype none
`include "byte_frame_aggregator_idle_flush_core_defines.svh"

module bfa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [bfa_pkg::BYTE_W-1:0]    out_byte,
    input wire logic                          out_last,
    input wire logic                          out_cause,
    input wire logic                          pready
);

    // a stalled frame beat holds
    `BFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_cause))

    // no request is taken while a frame is still being walked
    `BFA_ASSERT_NOW(a_busy_mid_frame, out_valid && !out_last, !in_ready)

    // taking a non-final beat: either the next beat is already up or the walk still runs
    `BFA_ASSERT_NEXT(a_walk_continues, out_valid && out_ready && !out_last, out_valid || !in_ready)

    // the APB port never waits
    `BFA_ASSERT_NOW(a_pready_high, in_valid || !in_valid, pready)

endmodule

bind byte_frame_aggregator_idle_flush_core bfa_checker u_bfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_byte  (frame.frame_byte),
    .out_last  (frame.frame_last),
    .out_cause (frame.flush_cause),
    .pready    (pready)
);

`default_nettype wire
